FILE: rtl/sgd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shake detector package
// Shared types and constants for the shake gesture detector: sequencer
// states, arithmetic unit operations, event codes and register indexes.
// ----------------------------------------------------------------------------
package sgd_pkg;

    // Sequencer states of the top level.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_JERK,
        ST_QUIET,
        ST_THRESH,
        ST_ELAPSED,
        ST_GAP,
        ST_READ,
        ST_AGE,
        ST_WINDOW,
        ST_STORE,
        ST_QUIET_END,
        ST_DONE
    } t_state;

    // Operations of the shared add/subtract unit.
    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    // Result of the shared unit: the 32-bit value and the borrow of a subtract.
    typedef struct packed {
        logic [31:0] value;
        logic        borrow;
    } t_alu_res;

    // Event codes on the result stream.
    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_WAKE  = 2'd1,
        EV_SHAKE = 2'd2
    } t_event;

    // Configuration register indexes.
    localparam logic [2:0] CFG_JERK_THRESHOLD = 3'd0;
    localparam logic [2:0] CFG_PEAK_GAP       = 3'd1;
    localparam logic [2:0] CFG_SHAKE_WINDOW   = 3'd2;
    localparam logic [2:0] CFG_SHAKE_COUNT    = 3'd3;
    localparam logic [2:0] CFG_QUIET_TIME     = 3'd4;

    // Register reset values.
    localparam logic [14:0] RST_JERK_THRESHOLD = 15'd800;
    localparam logic [15:0] RST_PEAK_GAP       = 16'd80;
    localparam logic [15:0] RST_SHAKE_WINDOW   = 16'd1000;
    localparam logic [3:0]  RST_SHAKE_COUNT    = 4'd3;
    localparam logic [15:0] RST_QUIET_TIME     = 16'd1500;

endpackage

FILE: rtl/shake_gesture_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shake gesture detector
// Turns timestamped acceleration magnitude samples into wake and shake events
// using one shared adder under a small sequencer.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Transaction                  Payload
//  s_axis    in         tvalid & tready              magnitude, timestamp
//  m_axis    out        tvalid & tready              event_res
//  cfg       in         i_cfg_we (no handshake)      register index, data
//
// A sample that makes no peak skips the pruning loop; one that makes a peak
// walks the stored peak times in it, each stored time costing a read and two
// adder passes, and a shake adds a step that sets the refractory end.
// Reset is synchronous and active low and leaves the store empty at once.
// The input is not ready while a sample is in work; a finished event waits
// in the output register, and the sequencer holds until that register frees.
// ----------------------------------------------------------------------------
module shake_gesture_detector #(
    parameter int PEAK_CAPACITY = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input samples.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // [14:0] magnitude, [46:15] timestamp
    // Result events.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [1:0] event_res
    // Configuration writes.
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int CW = $clog2(PEAK_CAPACITY + 1);
    localparam int AW = (PEAK_CAPACITY > 1) ? $clog2(PEAK_CAPACITY) : 1;
    localparam logic [CW-1:0]   CAP   = CW'(PEAK_CAPACITY);
    localparam logic [CW+3:0]   CAP_X = (CW + 4)'(PEAK_CAPACITY);

    // Configuration registers.
    logic [14:0] r_jerk_threshold;
    logic [15:0] r_peak_gap;
    logic [15:0] r_shake_window;
    logic [3:0]  r_shake_count;
    logic [15:0] r_quiet_time;

    // Detector state.
    logic [14:0]   r_prev_mag;
    logic          r_have_prev;
    logic [CW-1:0] r_count;
    logic [31:0]   r_last_peak;
    logic [31:0]   r_quiet_until;
    logic          r_quiet_active;

    // Per-sample working registers.
    sgd_pkg::t_state n_state, r_state;
    logic [14:0]     r_mag;
    logic [31:0]     r_now;
    logic [31:0]     r_tmp;
    logic            r_flag;
    logic [14:0]     r_jerk;
    logic [CW-1:0]   r_rd;
    logic [CW-1:0]   r_wr;
    sgd_pkg::t_event r_event;

    // Output register.
    logic            r_out_valid;
    sgd_pkg::t_event r_out_event;

    // Datapath control.
    logic              w_in_accept;
    logic              w_cfg_hit;
    logic              w_out_free;
    logic [31:0]       w_alu_a;
    logic [31:0]       w_alu_b;
    sgd_pkg::t_alu_op  w_alu_op;
    sgd_pkg::t_alu_res w_alu;
    logic              w_mem_we;
    logic [AW-1:0]     w_mem_waddr;
    logic [31:0]       w_mem_wdata;
    logic              w_mem_re;
    logic [31:0]       w_mem_rdata;
    logic              w_more;
    logic              w_room;
    logic [CW-1:0]     w_count_new;
    logic              w_is_shake;
    logic              w_cfg_clamp;

    assign w_in_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_cfg_hit   = i_cfg_we && (i_cfg_index <= sgd_pkg::CFG_QUIET_TIME);
    assign w_out_free  = !r_out_valid || i_m_axis_tready;
    assign w_more      = (r_rd < r_count);
    assign w_room      = (r_wr < CAP);
    assign w_count_new = w_room ? r_wr + CW'(1) : r_wr;
    assign w_is_shake  = ({4'd0, w_count_new} >= {{CW{1'b0}}, r_shake_count});
    assign w_cfg_clamp = ({{CW{1'b0}}, i_cfg_data[3:0]} > CAP_X);

    // Shared adder.
    sgd_addsub u_addsub (
        .i_a  (w_alu_a),
        .i_b  (w_alu_b),
        .i_op (w_alu_op),
        .o_res(w_alu)
    );

    // Stored peak times.
    sgd_peak_mem #(
        .DEPTH(PEAK_CAPACITY),
        .AW   (AW)
    ) u_peak_mem (
        .i_clk  (i_clk),
        .i_we   (w_mem_we),
        .i_waddr(w_mem_waddr),
        .i_wdata(w_mem_wdata),
        .i_re   (w_mem_re),
        .i_raddr(r_rd[AW-1:0]),
        .o_rdata(w_mem_rdata)
    );

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sgd_pkg::ST_IDLE:    if (w_in_accept) n_state = sgd_pkg::ST_DIFF;
            sgd_pkg::ST_DIFF:    n_state = sgd_pkg::ST_JERK;
            sgd_pkg::ST_JERK:    n_state = sgd_pkg::ST_QUIET;
            sgd_pkg::ST_QUIET: begin
                n_state = (r_quiet_active && w_alu.borrow) ? sgd_pkg::ST_DONE
                                                           : sgd_pkg::ST_THRESH;
            end
            sgd_pkg::ST_THRESH: begin
                n_state = w_alu.borrow ? sgd_pkg::ST_DONE : sgd_pkg::ST_ELAPSED;
            end
            sgd_pkg::ST_ELAPSED: n_state = sgd_pkg::ST_GAP;
            sgd_pkg::ST_GAP: begin
                n_state = (w_alu.borrow && (r_last_peak != 32'd0)) ? sgd_pkg::ST_DONE
                                                                   : sgd_pkg::ST_READ;
            end
            sgd_pkg::ST_READ:    n_state = w_more ? sgd_pkg::ST_AGE : sgd_pkg::ST_STORE;
            sgd_pkg::ST_AGE:     n_state = sgd_pkg::ST_WINDOW;
            sgd_pkg::ST_WINDOW:  n_state = sgd_pkg::ST_READ;
            sgd_pkg::ST_STORE: begin
                n_state = w_is_shake ? sgd_pkg::ST_QUIET_END : sgd_pkg::ST_DONE;
            end
            sgd_pkg::ST_QUIET_END: n_state = sgd_pkg::ST_DONE;
            sgd_pkg::ST_DONE:    if (w_out_free) n_state = sgd_pkg::ST_IDLE;
            default:             n_state = sgd_pkg::ST_IDLE;
        endcase
    end

    // Output logic of the sequencer: handshake, adder operands and store ports.
    always_comb begin
        o_s_axis_tready = 1'b0;
        w_alu_a         = 32'd0;
        w_alu_b         = 32'd0;
        w_alu_op        = sgd_pkg::ALU_SUB;
        w_mem_we        = 1'b0;
        w_mem_waddr     = r_wr[AW-1:0];
        w_mem_wdata     = w_mem_rdata;
        w_mem_re        = 1'b0;
        unique case (r_state)
            sgd_pkg::ST_IDLE: o_s_axis_tready = 1'b1;
            sgd_pkg::ST_DIFF: begin
                w_alu_a = {17'd0, r_mag};
                w_alu_b = {17'd0, r_prev_mag};
            end
            sgd_pkg::ST_JERK: begin
                w_alu_a = {17'd0, r_prev_mag};
                w_alu_b = {17'd0, r_mag};
            end
            sgd_pkg::ST_QUIET: begin
                w_alu_a = r_now;
                w_alu_b = r_quiet_until;
            end
            sgd_pkg::ST_THRESH: begin
                w_alu_a = {17'd0, r_jerk};
                w_alu_b = {17'd0, r_jerk_threshold};
            end
            sgd_pkg::ST_ELAPSED: begin
                w_alu_a = r_now;
                w_alu_b = r_last_peak;
            end
            sgd_pkg::ST_GAP: begin
                w_alu_a = r_tmp;
                w_alu_b = {16'd0, r_peak_gap};
            end
            sgd_pkg::ST_READ: w_mem_re = w_more;
            sgd_pkg::ST_AGE: begin
                w_alu_a = r_now;
                w_alu_b = w_mem_rdata;
            end
            sgd_pkg::ST_WINDOW: begin
                w_alu_a  = r_tmp;
                w_alu_b  = {16'd0, r_shake_window};
                w_mem_we = w_alu.borrow;
            end
            sgd_pkg::ST_STORE: begin
                w_mem_we    = w_room;
                w_mem_wdata = r_now;
            end
            sgd_pkg::ST_QUIET_END: begin
                w_alu_a  = r_now;
                w_alu_b  = {16'd0, r_quiet_time};
                w_alu_op = sgd_pkg::ALU_ADD;
            end
            sgd_pkg::ST_DONE: ;
            default: ;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sgd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers; a write beyond the register list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jerk_threshold <= sgd_pkg::RST_JERK_THRESHOLD;
            r_peak_gap       <= sgd_pkg::RST_PEAK_GAP;
            r_shake_window   <= sgd_pkg::RST_SHAKE_WINDOW;
            r_shake_count    <= (CAP_X < {{CW{1'b0}}, sgd_pkg::RST_SHAKE_COUNT})
                                ? CAP_X[3:0] : sgd_pkg::RST_SHAKE_COUNT;
            r_quiet_time     <= sgd_pkg::RST_QUIET_TIME;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                sgd_pkg::CFG_JERK_THRESHOLD: r_jerk_threshold <= i_cfg_data[14:0];
                sgd_pkg::CFG_PEAK_GAP:       r_peak_gap       <= i_cfg_data;
                sgd_pkg::CFG_SHAKE_WINDOW:   r_shake_window   <= i_cfg_data;
                sgd_pkg::CFG_SHAKE_COUNT: begin
                    r_shake_count <= w_cfg_clamp ? CAP_X[3:0] : i_cfg_data[3:0];
                end
                sgd_pkg::CFG_QUIET_TIME:     r_quiet_time     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Detector state; cleared by reset and by any register write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_cfg_hit) begin
            r_prev_mag     <= 15'd0;
            r_have_prev    <= 1'b0;
            r_count        <= '0;
            r_last_peak    <= 32'd0;
            r_quiet_until  <= 32'd0;
            r_quiet_active <= 1'b0;
        end else begin
            unique case (r_state)
                sgd_pkg::ST_JERK: begin
                    r_prev_mag  <= r_mag;
                    r_have_prev <= 1'b1;
                end
                sgd_pkg::ST_QUIET: begin
                    if (!w_alu.borrow) begin
                        r_quiet_active <= 1'b0;
                    end
                end
                sgd_pkg::ST_GAP: begin
                    if (!(w_alu.borrow && (r_last_peak != 32'd0))) begin
                        r_last_peak <= r_now;
                    end
                end
                sgd_pkg::ST_STORE: begin
                    if (w_is_shake) begin
                        r_count        <= '0;
                        r_quiet_active <= 1'b1;
                    end else begin
                        r_count <= w_count_new;
                    end
                end
                sgd_pkg::ST_QUIET_END: r_quiet_until <= w_alu.value;
                default: ;
            endcase
        end
    end

    // Working registers for the sample in progress.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            sgd_pkg::ST_IDLE: begin
                r_mag   <= i_s_axis_tdata[14:0];
                r_now   <= i_s_axis_tdata[46:15];
                r_event <= sgd_pkg::EV_NONE;
            end
            sgd_pkg::ST_DIFF: begin
                r_tmp  <= w_alu.value;
                r_flag <= w_alu.borrow;
            end
            sgd_pkg::ST_JERK: begin
                if (!r_have_prev) begin
                    r_jerk <= 15'd0;
                end else begin
                    r_jerk <= r_flag ? w_alu.value[14:0] : r_tmp[14:0];
                end
            end
            sgd_pkg::ST_ELAPSED: r_tmp <= w_alu.value;
            sgd_pkg::ST_GAP: begin
                r_rd <= '0;
                r_wr <= '0;
            end
            sgd_pkg::ST_AGE: r_tmp <= w_alu.value;
            sgd_pkg::ST_WINDOW: begin
                r_rd <= r_rd + CW'(1);
                if (w_alu.borrow) begin
                    r_wr <= r_wr + CW'(1);
                end
            end
            sgd_pkg::ST_STORE: begin
                r_event <= w_is_shake ? sgd_pkg::EV_SHAKE : sgd_pkg::EV_WAKE;
            end
            default: ;
        endcase
    end

    // Output register: loaded when the sequencer finishes and the slot is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == sgd_pkg::ST_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == sgd_pkg::ST_DONE && w_out_free) begin
            r_out_event <= r_event;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out_event};

endmodule

FILE: rtl/sgd_addsub.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared add/subtract unit
// One 32-bit adder used by the sequencer for every difference, compare and
// sum of the detector. A subtract reports a borrow when a is below b.
// ----------------------------------------------------------------------------
module sgd_addsub (
    input  logic             [31:0] i_a,
    input  logic             [31:0] i_b,
    input  sgd_pkg::t_alu_op        i_op,
    output sgd_pkg::t_alu_res       o_res
);

    logic        w_sub;
    logic [31:0] w_b;
    logic [32:0] w_sum;

    // Subtract as a plus inverted b plus one; the carry out is the inverse borrow.
    always_comb begin
        w_sub       = (i_op == sgd_pkg::ALU_SUB);
        w_b         = w_sub ? ~i_b : i_b;
        w_sum       = {1'b0, i_a} + {1'b0, w_b} + {32'd0, w_sub};
        o_res.value = w_sum[31:0];
        o_res.borrow = w_sub ? ~w_sum[32] : 1'b0;
    end

endmodule

FILE: rtl/sgd_peak_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peak time store
// Holds the timestamps of the peaks still counted toward a shake. One write
// port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sgd_peak_mem #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [31:0]   o_rdata
);

    logic [31:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

FILE: sim/shake_gesture_detector_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shake detector event checker
// Watches the sample, event and configuration ports of the shake gesture
// detector. It keeps its own model of the detector state, predicts one event
// per accepted sample and compares each accepted event with the oldest
// prediction. Errors and the number of events still owed go to the top.
// ----------------------------------------------------------------------------
module shake_gesture_detector_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // [14:0] magnitude, [46:15] timestamp
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [7:0]  i_m_axis_tdata,   // [1:0] event_res
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_error_count,
    output int          o_backlog
);

    localparam int PEAK_SLOTS   = 8;
    localparam int REPORT_LIMIT = 10;

    // Register copies.
    logic [14:0] jerk_min;
    logic [15:0] debounce_ms;
    logic [15:0] window_ms;
    logic [3:0]  peaks_needed;
    logic [15:0] quiet_ms;

    // Detector history.
    logic [14:0] prev_mag;
    logic        prev_valid;
    int unsigned peaks_held;
    logic [31:0] peak_stamp [PEAK_SLOTS];
    logic [31:0] last_peak;
    logic [31:0] quiet_end;
    logic        in_quiet;

    sgd_pkg::t_event owed_events [$];
    sgd_pkg::t_event want;
    int              errors;

    initial o_error_count = 0;
    initial o_backlog = 0;
    initial errors = 0;

    // Forget everything learnt from earlier samples.
    function automatic void clear_history();
        prev_mag   = '0;
        prev_valid = 1'b0;
        peaks_held = 0;
        for (int i = 0; i < PEAK_SLOTS; i++) begin
            peak_stamp[i] = '0;
        end
        last_peak  = '0;
        quiet_end  = '0;
        in_quiet   = 1'b0;
    endfunction

    // A register write stores the masked value and restarts detection; an
    // unused index changes nothing.
    function automatic void load_register(input logic [2:0] idx, input logic [15:0] data);
        case (idx)
            sgd_pkg::CFG_JERK_THRESHOLD: jerk_min = data[14:0];
            sgd_pkg::CFG_PEAK_GAP:       debounce_ms = data;
            sgd_pkg::CFG_SHAKE_WINDOW:   window_ms = data;
            sgd_pkg::CFG_SHAKE_COUNT: begin
                peaks_needed = (data[3:0] > PEAK_SLOTS) ? 4'(PEAK_SLOTS) : data[3:0];
            end
            sgd_pkg::CFG_QUIET_TIME:     quiet_ms = data;
            default:                     return;
        endcase
        clear_history();
    endfunction

    // Event that one sample should produce, updating the history on the way.
    function automatic sgd_pkg::t_event classify_sample(input logic [14:0] mag,
                                                        input logic [31:0] now);
        logic [14:0] jerk;
        logic [31:0] elapsed;
        int unsigned kept;
        jerk = '0;
        if (prev_valid) begin
            jerk = (mag >= prev_mag) ? mag - prev_mag : prev_mag - mag;
        end
        prev_mag   = mag;
        prev_valid = 1'b1;

        // The refractory period ends on the first sample at or past its end.
        if (in_quiet) begin
            if (now >= quiet_end) begin
                in_quiet = 1'b0;
            end else begin
                return sgd_pkg::EV_NONE;
            end
        end
        if (jerk < jerk_min) begin
            return sgd_pkg::EV_NONE;
        end
        elapsed = now - last_peak;
        if (last_peak != '0 && elapsed < {16'd0, debounce_ms}) begin
            return sgd_pkg::EV_NONE;
        end
        last_peak = now;

        // Keep only the peaks still inside the window, then add this one.
        kept = 0;
        for (int i = 0; i < peaks_held; i++) begin
            elapsed = now - peak_stamp[i];
            if (elapsed < {16'd0, window_ms}) begin
                peak_stamp[kept] = peak_stamp[i];
                kept++;
            end
        end
        peaks_held = kept;
        if (peaks_held < PEAK_SLOTS) begin
            peak_stamp[peaks_held] = now;
            peaks_held++;
        end

        if (peaks_held >= peaks_needed) begin
            peaks_held = 0;
            quiet_end  = now + {16'd0, quiet_ms};
            in_quiet   = 1'b1;
            return sgd_pkg::EV_SHAKE;
        end
        return sgd_pkg::EV_WAKE;
    endfunction

    // Predict on each sample transaction, compare on each event transaction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            jerk_min      = sgd_pkg::RST_JERK_THRESHOLD;
            debounce_ms   = sgd_pkg::RST_PEAK_GAP;
            window_ms     = sgd_pkg::RST_SHAKE_WINDOW;
            peaks_needed  = sgd_pkg::RST_SHAKE_COUNT;
            quiet_ms      = sgd_pkg::RST_QUIET_TIME;
            clear_history();
            owed_events.delete();
        end else begin
            if (i_cfg_we) begin
                load_register(i_cfg_index, i_cfg_data);
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                owed_events.push_back(classify_sample(i_s_axis_tdata[14:0],
                                                      i_s_axis_tdata[46:15]));
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (owed_events.size() == 0) begin
                    if (errors < REPORT_LIMIT) begin
                        $display("%0t: event %0d arrived with no sample waiting",
                                 $realtime, i_m_axis_tdata[1:0]);
                    end
                    errors++;
                end else begin
                    want = owed_events.pop_front();
                    if (i_m_axis_tdata[1:0] !== want) begin
                        if (errors < REPORT_LIMIT) begin
                            $display("%0t: event mismatch, expected %0d (%s), got %0d",
                                     $realtime, want, want.name(), i_m_axis_tdata[1:0]);
                        end
                        errors++;
                    end
                end
            end
        end
        o_error_count <= errors;
        o_backlog     <= owed_events.size();
    end

endmodule

FILE: sim/shake_gesture_detector_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shake gesture detector testbench
// Drives timestamped magnitude samples and register writes into the detector
// while the checker predicts and compares the events. A directed opening
// walks through debounce, pruning, refractory periods and timestamp wrap;
// then several register settings, extremes included, each get random shake
// bursts, calm stretches, time jumps and noise, with random gaps on both
// streams and one long hold-off on the event side.
// ----------------------------------------------------------------------------
module shake_gesture_detector_tb;

    localparam int          MAG_MAX      = 32767;
    localparam int          PEAK_SLOTS   = 8;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          LIMIT_NS     = 20_000_000;
    localparam logic [2:0]  CFG_UNUSED_LO = 3'd5;
    localparam logic [2:0]  CFG_UNUSED_HI = 3'd7;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [47:0] i_s_axis_tdata = '0;    // [14:0] magnitude, [46:15] timestamp
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [7:0]  o_m_axis_tdata;         // [1:0] event_res
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    int          error_count;
    int          backlog;

    // Stimulus shaping: a mirror of the registers and the running sample stream.
    int          cur_thr = sgd_pkg::RST_JERK_THRESHOLD;
    int          cur_gap = sgd_pkg::RST_PEAK_GAP;
    int          cur_window = sgd_pkg::RST_SHAKE_WINDOW;
    int          cur_count = sgd_pkg::RST_SHAKE_COUNT;
    int          cur_quiet = sgd_pkg::RST_QUIET_TIME;
    logic [31:0] stamp = '0;
    int          last_mag = 0;
    int          sent = 0;
    bit          steady = 1'b0;
    bit          hold_req = 1'b0;
    bit          hold_done = 1'b0;

    shake_gesture_detector dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    shake_gesture_detector_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_error_count   (error_count),
        .o_backlog       (backlog)
    );

    // Clock and reset.
    always #5 i_clk = ~i_clk;

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Hard limit on the run.
    initial begin
        #(LIMIT_NS);
        $display("[shake_gesture_detector] ERROR");
        $finish;
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (steady) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Magnitude whose jerk from the previous one reaches the threshold.
    function automatic logic [14:0] peak_mag(input int prev, input int thr);
        if (prev + thr <= MAG_MAX && (prev < thr || $urandom_range(0, 1) == 1)) begin
            return 15'($urandom_range(prev + thr, MAG_MAX));
        end
        if (prev >= thr) begin
            return 15'($urandom_range(0, prev - thr));
        end
        return (prev < MAG_MAX / 2) ? 15'(MAG_MAX) : 15'd0;
    endfunction

    // Event receiver: random stalls, and one long hold-off when asked.
    initial begin
        int stall;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                stall = pick_gap();
                if (stall > 0) begin
                    i_m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            i_m_axis_tready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // One sample transaction, after an optional gap.
    task automatic send_sample(input logic [14:0] mag, input logic [31:0] ts);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {1'b0, ts, mag};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        last_mag = mag;
        sent++;
    endtask

    // One register write; the caller lowers the write enable after the last.
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            sgd_pkg::CFG_JERK_THRESHOLD: cur_thr = data[14:0];
            sgd_pkg::CFG_PEAK_GAP:       cur_gap = data;
            sgd_pkg::CFG_SHAKE_WINDOW:   cur_window = data;
            sgd_pkg::CFG_SHAKE_COUNT: begin
                cur_count = (data[3:0] > PEAK_SLOTS) ? PEAK_SLOTS : data[3:0];
            end
            sgd_pkg::CFG_QUIET_TIME:     cur_quiet = data;
            default:                     ;
        endcase
    endtask

    task automatic write_all(input logic [15:0] thr, input logic [15:0] gap,
                             input logic [15:0] win, input logic [15:0] cnt,
                             input logic [15:0] quiet);
        write_reg(sgd_pkg::CFG_JERK_THRESHOLD, thr);
        write_reg(sgd_pkg::CFG_PEAK_GAP, gap);
        write_reg(sgd_pkg::CFG_SHAKE_WINDOW, win);
        write_reg(sgd_pkg::CFG_SHAKE_COUNT, cnt);
        write_reg(sgd_pkg::CFG_QUIET_TIME, quiet);
        i_cfg_we <= 1'b0;
    endtask

    // Random register value, with extremes and junk in the unused data bits.
    function automatic logic [15:0] pick_register_value(input int k);
        logic [15:0] v;
        int          r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'h0000;
        if (r == 1) return 16'hFFFF;
        case (k)
            sgd_pkg::CFG_JERK_THRESHOLD: begin
                v = 16'($urandom_range(0, 3000));
                v[15] = 1'($urandom_range(0, 1));
            end
            sgd_pkg::CFG_PEAK_GAP:     v = 16'($urandom_range(0, 200));
            sgd_pkg::CFG_SHAKE_WINDOW: v = 16'($urandom_range(50, 3000));
            sgd_pkg::CFG_SHAKE_COUNT: begin
                v = 16'($urandom_range(0, 9));
                v[15:4] = 12'($urandom_range(0, 4095));
            end
            default:                   v = 16'($urandom_range(0, 3000));
        endcase
        return v;
    endfunction

    task automatic random_setup();
        int forced;
        forced = $urandom_range(sgd_pkg::CFG_JERK_THRESHOLD, sgd_pkg::CFG_QUIET_TIME);
        for (int k = sgd_pkg::CFG_JERK_THRESHOLD; k <= sgd_pkg::CFG_QUIET_TIME; k++) begin
            if (k == forced || $urandom_range(0, 9) < 7) begin
                write_reg(3'(k), pick_register_value(k));
            end
        end
        i_cfg_we <= 1'b0;
    endtask

    // Let every owed event arrive and the sequencer go quiet.
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (backlog != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Well-formed shake attempt: alternating large jerks spaced around the gap.
    task automatic run_burst();
        int n;
        int needed;
        int spare;
        int step;
        logic [14:0] mag;
        n = $urandom_range(2, 10);
        needed = (cur_count == 0) ? 1 : cur_count;
        spare = (cur_window > cur_gap * needed) ? (cur_window - cur_gap * needed) / needed : 20;
        repeat (n) begin
            if ($urandom_range(0, 4) == 0) begin
                step = $urandom_range(0, cur_gap);
            end else begin
                step = cur_gap + $urandom_range(0, spare);
            end
            stamp = stamp + step;
            if (cur_thr > 0 && last_mag + cur_thr - 1 <= MAG_MAX
                    && $urandom_range(0, 9) == 0) begin
                mag = 15'(last_mag + cur_thr - 1);    // jerk one short of a peak
            end else begin
                mag = peak_mag(last_mag, cur_thr);
            end
            send_sample(mag, stamp);
        end
    endtask

    // Calm stretch: small jerks that stay under the threshold.
    task automatic run_calm();
        int n;
        int r;
        n = $urandom_range(1, 8);
        repeat (n) begin
            stamp = stamp + $urandom_range(1, 60);
            r = $urandom_range(0, (cur_thr > 0) ? ((cur_thr > 4000) ? 4000 : cur_thr - 1) : 0);
            send_sample(15'((last_mag >= MAG_MAX / 2) ? last_mag - r : last_mag + r), stamp);
        end
    endtask

    // Single peak after a jump onto a timing boundary or across the wrap.
    task automatic run_jump();
        case ($urandom_range(0, 5))
            0: stamp = stamp + cur_quiet + $urandom_range(0, 2) - 1;
            1: stamp = stamp + cur_window + $urandom_range(0, 2) - 1;
            2: stamp = stamp + cur_gap + $urandom_range(0, 2) - 1;
            3: stamp = stamp + $urandom;
            4: stamp = 32'hFFFF_FFFF - $urandom_range(0, 3000);
            default: stamp = '0;
        endcase
        send_sample(peak_mag(last_mag, cur_thr), stamp);
    endtask

    // Noise: any magnitude at any time.
    task automatic run_noise();
        logic [31:0] ts;
        repeat ($urandom_range(1, 4)) begin
            ts = $urandom;
            if ($urandom_range(0, 1) == 1) begin
                stamp = ts;
            end
            send_sample(15'($urandom_range(0, MAG_MAX)), ts);
        end
    endtask

    task automatic random_items(input int quota);
        int goal;
        int r;
        goal = sent + quota;
        while (sent < goal) begin
            r = $urandom_range(0, 99);
            if (r < 55)      run_burst();
            else if (r < 75) run_calm();
            else if (r < 88) run_jump();
            else             run_noise();
        end
    endtask

    // Stimulus and verdict.
    initial begin
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);

        // An unused register index must leave everything alone.
        write_reg(CFG_UNUSED_HI, 16'hFFFF);
        i_cfg_we <= 1'b0;

        // Default registers: first sample, peak at time zero, debounce,
        // shake, refractory period, threshold edge, pruning, wrap.
        send_sample(15'd0, 32'd0);
        send_sample(15'd32767, 32'd0);
        send_sample(15'd0, 32'd10);
        send_sample(15'd32767, 32'd50);
        send_sample(15'd0, 32'd90);
        send_sample(15'd32767, 32'd1589);
        send_sample(15'd0, 32'd1590);
        send_sample(15'd799, 32'd1700);
        send_sample(15'd1599, 32'd1800);
        send_sample(15'd0, 32'd2590);
        send_sample(15'd32767, 32'hFFFF_FFC0);
        send_sample(15'd0, 32'h0000_0010);
        send_sample(15'd32767, 32'h0000_0020);
        send_sample(15'd0, 32'h0000_0060);
        send_sample(15'd32767, 32'hFFFF_FF00);
        send_sample(15'd0, 32'hFFFF_FF60);
        // This shake's refractory end wraps past zero, so the next sample ends it.
        send_sample(15'd32767, 32'hFFFF_FFC0);
        send_sample(15'd0, 32'hFFFF_FFE0);
        send_sample(15'd32767, 32'h0000_0040);
        stamp = 32'h0000_0040;
        random_items(200);

        // Zero threshold, gap and quiet time; every peak is a shake.
        settle();
        write_all(16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000);
        random_items(150);

        // Largest values; the count is clamped and the window drops everything.
        settle();
        write_all(16'hFFFF, 16'hFFFF, 16'h0000, 16'h000F, 16'hFFFF);
        random_items(150);

        // Single-peak shakes with no window, streamed without idling.
        settle();
        write_reg(sgd_pkg::CFG_SHAKE_COUNT, 16'h0001);
        write_reg(sgd_pkg::CFG_JERK_THRESHOLD, 16'd300);
        write_reg(sgd_pkg::CFG_QUIET_TIME, 16'd5);
        write_reg(CFG_UNUSED_LO, 16'h1234);
        i_cfg_we <= 1'b0;
        steady = 1'b1;
        random_items(150);
        steady = 1'b0;

        // Full count of peaks, with a long hold-off on the event side.
        settle();
        write_all(16'd400, 16'd30, 16'd600, 16'd8, 16'd200);
        hold_req = 1'b1;
        random_items(200);

        // Random settings.
        repeat (5) begin
            settle();
            random_setup();
            random_items(170);
        end
        settle();

        if (error_count == 0) begin
            $display("[shake_gesture_detector] OK");
        end else begin
            $display("[shake_gesture_detector] ERROR");
        end
        $finish;
    end

endmodule
